// ===== hw/rtl/iphp_pkg.sv =====
// iphp_pkg: shared types and constants for the IPv4 header parser.
// Used by every module of the block; no dependencies.
package iphp_pkg;

    localparam int HDR_BYTES   = 20;
    localparam int HDR_IDX_W   = 5;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0]       IP_VERSION  = 4'd4;
    localparam logic [3:0]       MIN_IHL     = 4'd5;
    localparam logic [7:0]       IHL_MASK    = 8'h0f;
    localparam logic [15:0]      MF_FLAG     = 16'h2000;
    localparam logic [15:0]      FRAG_OFFSET = 16'h1fff;
    localparam logic [15:0]      SUM_GOOD    = 16'hffff;
    localparam logic [CNT_W-1:0] CNT_MAX     = 16'hffff;
    localparam logic [CNT_W-1:0] HDR_LEN     = 16'd20;
    localparam logic [CNT_W-1:0] HDR_LAST    = 16'd19;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_VERSION  = 3'd2,
        ST_BAD_IHL  = 3'd3,
        ST_OPTIONS  = 3'd4,
        ST_CHECKSUM = 3'd5,
        ST_LENGTH   = 3'd6,
        ST_FRAG     = 3'd7
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        logic        has_pay;
        logic        has_verdict;
        logic [7:0]  pay_byte;
        status_t     status;
        logic [7:0]  tos_byte;
        logic [15:0] identification;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] payload_length;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  tos_byte;
        logic [15:0] identification;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] payload_length;
        logic        end_of_run;
    } result_t;

endpackage

// ===== hw/rtl/iphp_front.sv =====
// iphp_front: per-byte header capture, checksum accumulation and classification.
// Depends on iphp_pkg; emits one command per transaction that yields results.
module iphp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          q_full,
    output logic          push,
    output iphp_pkg::cmd_t cmd
);
    import iphp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             header_ok_reg, header_ok_next;
    status_t          pre_reg, pre_next;
    logic [7:0]       hdr_reg [HDR_BYTES];

    logic [7:0]       hdr_cur [HDR_BYTES];
    logic             accept;
    logic             in_hdr;
    logic             at_last_hdr;
    logic [SUM_W-1:0] sum_add;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    logic [3:0]       ver;
    logic [3:0]       ihl;
    logic [15:0]      tot_cur;
    logic [15:0]      tot_reg;
    logic [15:0]      frag;
    status_t          pre_comb;
    status_t          pre_use;
    status_t          verdict;
    logic [CNT_W-1:0] n_rx;
    logic             emit_pay;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign in_hdr   = count_reg < HDR_LEN;
    assign at_last_hdr = count_reg == HDR_LAST;

    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_cur[i] = hdr_reg[i];
        end
        if (at_last_hdr)
        begin
            hdr_cur[HDR_BYTES-1] = data_byte;
        end
    end

    assign sum_add  = count_reg[0] ? {12'd0, data_byte} : {4'd0, data_byte, 8'd0};
    assign sum_next = in_hdr ? sum_reg + sum_add : sum_reg;
    assign fold1    = {1'b0, sum_next[15:0]} + {13'd0, sum_next[19:16]};
    assign fold2    = fold1[15:0] + {15'd0, fold1[16]};

    assign ver     = hdr_cur[0][7:4];
    assign ihl     = 4'(hdr_cur[0] & IHL_MASK);
    assign tot_cur = {hdr_cur[2], hdr_cur[3]};
    assign tot_reg = {hdr_reg[2], hdr_reg[3]};
    assign frag    = {hdr_cur[6], hdr_cur[7]};

    // header judged as if the whole packet were present
    always_comb
    begin
        priority if (ver != IP_VERSION)           pre_comb = ST_VERSION;
        else if (ihl < MIN_IHL)                   pre_comb = ST_BAD_IHL;
        else if (ihl != MIN_IHL)                  pre_comb = ST_OPTIONS;
        else if (fold2 != SUM_GOOD)               pre_comb = ST_CHECKSUM;
        else if (tot_cur < HDR_LEN)               pre_comb = ST_LENGTH;
        else if ((frag & (MF_FLAG | FRAG_OFFSET)) != 16'd0) pre_comb = ST_FRAG;
        else                                      pre_comb = ST_OK;
    end

    assign pre_use = at_last_hdr ? pre_comb : pre_reg;
    assign n_rx    = (count_reg == CNT_MAX) ? count_reg : count_reg + 16'd1;

    always_comb
    begin
        priority if (n_rx < HDR_LEN)                          verdict = ST_SHORT;
        else if (pre_use != ST_OK && pre_use != ST_FRAG)      verdict = pre_use;
        else if (tot_cur > n_rx)                              verdict = ST_LENGTH;
        else                                                  verdict = pre_use;
    end

    assign emit_pay = !in_hdr && header_ok_reg && (count_reg != CNT_MAX)
                      && (count_reg < tot_reg);

    always_comb
    begin
        cmd             = '0;
        cmd.has_pay     = emit_pay;
        cmd.has_verdict = last_byte;
        cmd.pay_byte    = data_byte;
        cmd.status      = verdict;
        if (verdict == ST_OK)
        begin
            cmd.tos_byte            = hdr_cur[1];
            cmd.identification      = {hdr_cur[4], hdr_cur[5]};
            cmd.ttl                 = hdr_cur[8];
            cmd.protocol            = hdr_cur[9];
            cmd.source_address      = {hdr_cur[12], hdr_cur[13], hdr_cur[14], hdr_cur[15]};
            cmd.destination_address = {hdr_cur[16], hdr_cur[17], hdr_cur[18], hdr_cur[19]};
            cmd.payload_length      = tot_cur - HDR_LEN;
        end
    end

    assign push = accept && (emit_pay || last_byte);

    always_comb
    begin
        count_next     = count_reg;
        header_ok_next = header_ok_reg;
        pre_next       = pre_reg;
        if (accept)
        begin
            count_next = n_rx;
            if (at_last_hdr)
            begin
                pre_next       = pre_comb;
                header_ok_next = pre_comb == ST_OK;
            end
            if (last_byte)
            begin
                count_next     = '0;
                header_ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            header_ok_reg <= 1'b0;
            pre_reg       <= ST_OK;
        end
        else
        begin
            count_reg     <= count_next;
            header_ok_reg <= header_ok_next;
            pre_reg       <= pre_next;
            if (accept)
            begin
                sum_reg <= last_byte ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_hdr)
        begin
            hdr_reg[count_reg[HDR_IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

// ===== hw/rtl/iphp_queue.sv =====
// iphp_queue: small command queue between the classifier and the result stage.
// Depends on iphp_pkg.
module iphp_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  iphp_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           q_valid,
    output iphp_pkg::cmd_t head
);
    import iphp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    property p_no_push_full;
        @(posedge clk) disable iff (!rst_n) full |-> !push;
    endproperty
    a_no_push_full: assert property (p_no_push_full) else $error("push into full queue");

    property p_no_pop_empty;
        @(posedge clk) disable iff (!rst_n) pop |-> q_valid;
    endproperty
    a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

    property p_cnt_range;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= QCNT_W'(QUEUE_DEPTH);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count overflow");

endmodule

// ===== hw/rtl/iphp_back.sv =====
// iphp_back: expands queued commands into payload and verdict results.
// Depends on iphp_pkg; holds the output register of the block.
module iphp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  iphp_pkg::cmd_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output iphp_pkg::result_t res
);
    import iphp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    pay_done_reg, pay_done_next;
    result_t res_reg, res_next;
    logic    load;
    logic    take_pay;

    assign load     = !out_valid_reg || out_ready;
    assign take_pay = head.has_pay && !pay_done_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pay_done_next  = pay_done_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                res_next = '0;
                if (take_pay)
                begin
                    res_next.kind         = KIND_PAYLOAD;
                    res_next.payload_byte = head.pay_byte;
                    res_next.status       = ST_OK;
                    pop                   = !head.has_verdict;
                    pay_done_next         = head.has_verdict;
                end
                else
                begin
                    res_next.kind                = KIND_VERDICT;
                    res_next.status              = head.status;
                    res_next.tos_byte            = head.tos_byte;
                    res_next.identification      = head.identification;
                    res_next.ttl                 = head.ttl;
                    res_next.protocol            = head.protocol;
                    res_next.source_address      = head.source_address;
                    res_next.destination_address = head.destination_address;
                    res_next.payload_length      = head.payload_length;
                    res_next.end_of_run          = 1'b1;
                    pop                          = 1'b1;
                    pay_done_next                = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pay_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pay_done_reg  <= pay_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    property p_pay_done_head;
        @(posedge clk) disable iff (!rst_n)
            pay_done_reg |-> (q_valid && head.has_pay && head.has_verdict);
    endproperty
    a_pay_done_head: assert property (p_pay_done_head)
        else $error("split command lost its head entry");

    property p_split_then_verdict;
        @(posedge clk) disable iff (!rst_n)
            (load && q_valid && take_pay && head.has_verdict) |=> pay_done_reg;
    endproperty
    a_split_then_verdict: assert property (p_split_then_verdict)
        else $error("verdict half of command dropped");

    property p_verdict_pops;
        @(posedge clk) disable iff (!rst_n)
            (load && q_valid && !take_pay) |-> pop;
    endproperty
    a_verdict_pops: assert property (p_verdict_pops) else $error("verdict without pop");

endmodule

// ===== hw/rtl/ipv4_header_parser.sv =====
// ipv4_header_parser: streaming IPv4 header checker and payload forwarder, top level.
// Depends on iphp_pkg, iphp_front, iphp_queue, iphp_back.
//
// Takes one packet byte per transaction (last_byte marks the end) and can accept a byte
// every cycle while the queue is not full. Bytes past the 20-byte header, up to the
// header's length field, come out as payload results once the header checks clean; the
// last byte also yields a verdict result, so that byte can yield two results. A four-entry
// command queue sits between the byte classifier and the result register, so short output
// stalls do not stop input; each byte's command is queued before its result is registered.
module ipv4_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [7:0]  tos_byte,
    output logic [15:0] identification,
    output logic [7:0]  ttl,
    output logic [7:0]  protocol,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [15:0] payload_length,
    output logic        end_of_run
);
    import iphp_pkg::*;

    logic    q_full;
    logic    push;
    logic    pop;
    logic    q_valid;
    cmd_t    push_cmd;
    cmd_t    head;
    result_t res;

    iphp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    iphp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .head     (head)
    );

    iphp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind                = res.kind;
    assign payload_byte        = res.payload_byte;
    assign status              = res.status;
    assign tos_byte            = res.tos_byte;
    assign identification      = res.identification;
    assign ttl                 = res.ttl;
    assign protocol            = res.protocol;
    assign source_address      = res.source_address;
    assign destination_address = res.destination_address;
    assign payload_length      = res.payload_length;
    assign end_of_run          = res.end_of_run;

endmodule

// ===== verif/ipv4_header_parser_checker.sv =====
`timescale 1ns / 100ps
// ipv4_header_parser_checker: watches both channels of the IPv4 header parser, predicts
// each result from the accepted bytes and compares it field by field.
// Depends on iphp_pkg for the result layout, status codes and header constants.
module ipv4_header_parser_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [7:0]  payload_byte,
    input  logic [2:0]  status,
    input  logic [7:0]  tos_byte,
    input  logic [15:0] identification,
    input  logic [7:0]  ttl,
    input  logic [7:0]  protocol,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] payload_length,
    input  logic        end_of_run,
    output int          mismatches,
    output int          outstanding,
    output int          payloads_seen,
    output int          verdicts_seen
);
    import iphp_pkg::*;

    localparam int PRINT_LIMIT = 40;

    logic [15:0] byte_count;
    logic [7:0]  header_bytes [HDR_BYTES];
    logic [19:0] sum_acc;
    logic        header_good;
    result_t     awaited_results [$];

    int fail_total    = 0;
    int backlog       = 0;
    int payload_total = 0;
    int verdict_total = 0;

    assign mismatches    = fail_total;
    assign outstanding   = backlog;
    assign payloads_seen = payload_total;
    assign verdicts_seen = verdict_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_total < PRINT_LIMIT)
            $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
        fail_total++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic logic [15:0] header_word(input logic [4:0] pos);
        return {header_bytes[pos], header_bytes[pos + 5'd1]};
    endfunction

    // Status of a packet that has n bytes so far, checks in priority order.
    function automatic status_t judge_header(input logic [15:0] n);
        logic [19:0] folded;
        logic [15:0] tot;
        logic [15:0] frag;
        if (n < HDR_LEN)
            return ST_SHORT;
        if (header_bytes[0][7:4] != IP_VERSION)
            return ST_VERSION;
        if ((header_bytes[0] & IHL_MASK) < {4'd0, MIN_IHL})
            return ST_BAD_IHL;
        if ((header_bytes[0] & IHL_MASK) != {4'd0, MIN_IHL})
            return ST_OPTIONS;
        folded = {4'd0, sum_acc[15:0]} + {16'd0, sum_acc[19:16]};
        folded = {4'd0, folded[15:0]} + {16'd0, folded[19:16]};
        if (folded != {4'd0, SUM_GOOD})
            return ST_CHECKSUM;
        tot = header_word(5'd2);
        if (tot < HDR_LEN || tot > n)
            return ST_LENGTH;
        frag = header_word(5'd6);
        if ((frag & MF_FLAG) != 16'd0 || (frag & FRAG_OFFSET) != 16'd0)
            return ST_FRAG;
        return ST_OK;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        logic [15:0] idx;
        result_t     want;
        idx = byte_count;
        if (byte_count != CNT_MAX)
            byte_count = byte_count + 16'd1;
        if (idx < HDR_LEN)
        begin
            header_bytes[idx[4:0]] = b;
            sum_acc = sum_acc + (idx[0] ? {12'd0, b} : {4'd0, b, 8'd0});
            if (idx == HDR_LAST)
                header_good = (judge_header(CNT_MAX) == ST_OK);
        end
        else if (header_good && idx != CNT_MAX && idx < header_word(5'd2))
        begin
            want = '0;
            want.kind = KIND_PAYLOAD;
            want.payload_byte = b;
            want.status = ST_OK;
            awaited_results = {awaited_results, want};
        end
        if (is_last)
        begin
            want = '0;
            want.kind = KIND_VERDICT;
            want.status = judge_header(byte_count);
            want.end_of_run = 1'b1;
            if (want.status == ST_OK)
            begin
                want.tos_byte = header_bytes[1];
                want.identification = header_word(5'd4);
                want.ttl = header_bytes[8];
                want.protocol = header_bytes[9];
                want.source_address = {header_word(5'd12), header_word(5'd14)};
                want.destination_address = {header_word(5'd16), header_word(5'd18)};
                want.payload_length = header_word(5'd2) - HDR_LEN;
            end
            awaited_results = {awaited_results, want};
            byte_count = '0;
            sum_acc = '0;
            header_good = 1'b0;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with none expected", {31'd0, kind}, 32'd0);
            return;
        end
        want = awaited_results.pop_front();
        if (want.kind == KIND_VERDICT)
            verdict_total++;
        else
            payload_total++;
        check_field("kind", 32'(kind), 32'(want.kind));
        check_field("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
        check_field("status", 32'(status), 32'(want.status));
        check_field("tos_byte", 32'(tos_byte), 32'(want.tos_byte));
        check_field("identification", 32'(identification), 32'(want.identification));
        check_field("ttl", 32'(ttl), 32'(want.ttl));
        check_field("protocol", 32'(protocol), 32'(want.protocol));
        check_field("source_address", source_address, want.source_address);
        check_field("destination_address", destination_address, want.destination_address);
        check_field("payload_length", 32'(payload_length), 32'(want.payload_length));
        check_field("end_of_run", 32'(end_of_run), 32'(want.end_of_run));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count = '0;
            sum_acc = '0;
            header_good = 1'b0;
            awaited_results.delete();
            backlog <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_byte(data_byte, last_byte);
            backlog <= awaited_results.size();
        end
    end

endmodule

// ===== verif/ipv4_header_parser_tb.sv =====
`timescale 1ns / 100ps
// ipv4_header_parser_tb: drives IPv4 packets (directed corner cases, then random mixes
// under four handshake patterns) into the parser and gives the verdict.
// Depends on iphp_pkg, ipv4_header_parser and ipv4_header_parser_checker.
module ipv4_header_parser_tb;
    import iphp_pkg::*;

    localparam int          STALL_LIMIT  = 1000;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          PHASE_BYTES  = 60;
    localparam logic [15:0] DF_FLAG      = 16'h4000;

    typedef struct packed {
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  tos;
        logic [15:0] tot;
        logic [15:0] id;
        logic [15:0] frag;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic        bad_sum;
    } ip_header_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  tos_byte;
    logic [15:0] identification;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] payload_length;
    logic        end_of_run;

    int mismatches;
    int outstanding;
    int payloads_seen;
    int verdicts_seen;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int packets_sent       = 0;
    int bytes_sent         = 0;
    int quiet_cycles       = 0;

    ipv4_header_parser i_dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .kind                (kind),
        .payload_byte        (payload_byte),
        .status              (status),
        .tos_byte            (tos_byte),
        .identification      (identification),
        .ttl                 (ttl),
        .protocol            (protocol),
        .source_address      (source_address),
        .destination_address (destination_address),
        .payload_length      (payload_length),
        .end_of_run          (end_of_run)
    );

    ipv4_header_parser_checker i_checker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .kind                (kind),
        .payload_byte        (payload_byte),
        .status              (status),
        .tos_byte            (tos_byte),
        .identification      (identification),
        .ttl                 (ttl),
        .protocol            (protocol),
        .source_address      (source_address),
        .destination_address (destination_address),
        .payload_length      (payload_length),
        .end_of_run          (end_of_run),
        .mismatches          (mismatches),
        .outstanding         (outstanding),
        .payloads_seen       (payloads_seen),
        .verdicts_seen       (verdicts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Receiver stalls and sender gaps are random, so a long quiet stretch means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input ip_header_t h, input int unsigned n, input bit noise);
        logic [7:0]  hb [HDR_BYTES];
        logic [31:0] acc;
        logic [15:0] csum;
        int unsigned i;
        hb[0] = {h.ver, h.ihl};
        hb[1] = h.tos;
        {hb[2], hb[3]} = h.tot;
        {hb[4], hb[5]} = h.id;
        {hb[6], hb[7]} = h.frag;
        hb[8] = h.ttl;
        hb[9] = h.proto;
        hb[10] = 8'd0;
        hb[11] = 8'd0;
        {hb[12], hb[13], hb[14], hb[15]} = h.src;
        {hb[16], hb[17], hb[18], hb[19]} = h.dst;
        acc = '0;
        for (i = 0; i < HDR_BYTES; i += 2)
            acc = acc + {16'd0, hb[5'(i)], hb[5'(i + 1)]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        csum = ~acc[15:0];
        if (h.bad_sum)
            csum = csum ^ 16'($urandom_range(1, 65535));
        {hb[10], hb[11]} = csum;
        for (i = 0; i < n; i++)
        begin
            if (noise || i >= HDR_BYTES)
                send_byte(8'($urandom), i == n - 1);
            else
                send_byte(hb[5'(i)], i == n - 1);
        end
        packets_sent++;
    endtask

    function automatic ip_header_t good_header(input logic [15:0] tot);
        ip_header_t h;
        h.ver = IP_VERSION;
        h.ihl = MIN_IHL;
        h.tos = 8'($urandom);
        h.tot = tot;
        h.id = 16'($urandom);
        h.frag = $urandom_range(1) ? DF_FLAG : 16'd0;
        h.ttl = 8'($urandom);
        h.proto = 8'($urandom);
        h.src = $urandom;
        h.dst = $urandom;
        h.bad_sum = 1'b0;
        return h;
    endfunction

    // Sender holds off until every predicted result has been delivered.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic run_directed();
        ip_header_t h;
        send_packet(good_header(16'd20), 1, 1'b0);
        send_packet(good_header(16'd20), 19, 1'b0);
        send_packet(good_header(16'd20), 20, 1'b0);
        send_packet(good_header(16'd25), 25, 1'b0);
        h = good_header(16'd24);
        h.ver = 4'd6;
        send_packet(h, 24, 1'b0);
        h.ver = 4'd0;
        h.ihl = 4'd0;
        send_packet(h, 24, 1'b0);
        h = good_header(16'd24);
        h.ihl = 4'd0;
        send_packet(h, 24, 1'b0);
        h.ihl = 4'd4;
        send_packet(h, 24, 1'b0);
        h.ihl = 4'd15;
        send_packet(h, 24, 1'b0);
        h = good_header(16'd24);
        h.bad_sum = 1'b1;
        send_packet(h, 24, 1'b0);
        send_packet(good_header(16'd19), 24, 1'b0);
        send_packet(good_header(16'd0), 24, 1'b0);
        send_packet(good_header(16'd40), 30, 1'b0);
        h = good_header(16'd24);
        h.frag = MF_FLAG;
        send_packet(h, 24, 1'b0);
        h.frag = FRAG_OFFSET;
        send_packet(h, 24, 1'b0);
        h.frag = DF_FLAG;
        send_packet(h, 24, 1'b0);
        send_packet(good_header(16'd24), 30, 1'b0);
        h = '1;
        h.ver = IP_VERSION;
        h.ihl = MIN_IHL;
        h.tot = 16'd30;
        h.frag = DF_FLAG;
        h.bad_sum = 1'b0;
        send_packet(h, 30, 1'b0);
        h = '0;
        h.ver = IP_VERSION;
        h.ihl = MIN_IHL;
        h.tot = 16'd20;
        send_packet(h, 20, 1'b0);
        send_packet(good_header(16'd21), 21, 1'b1);
    endtask

    task automatic run_random(input int send_pct, input int stall_pct);
        ip_header_t  h;
        int unsigned pick;
        int unsigned tot;
        int unsigned n;
        int          start;
        bit          noise;
        sender_idle_pct = send_pct;
        receiver_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            pick = $urandom_range(99);
            tot = 20 + $urandom_range(24);
            h = good_header(16'(tot));
            n = tot;
            noise = 1'b0;
            if (pick < 55)
            begin
                if ($urandom_range(3) == 0)
                    n = tot + $urandom_range(1, 4);
            end
            else if (pick < 62)
            begin
                do
                    h.frag = 16'($urandom);
                while ((h.frag & (MF_FLAG | FRAG_OFFSET)) == 16'd0);
            end
            else if (pick < 70)
            begin
                n = 20 + $urandom_range(20);
                if ($urandom_range(1))
                    h.tot = 16'($urandom_range(19));
                else
                    h.tot = 16'($urandom_range(n + 1, 65535));
            end
            else if (pick < 78)
                h.bad_sum = 1'b1;
            else if (pick < 84)
            begin
                if ($urandom_range(1))
                    do
                        h.ver = 4'($urandom);
                    while (h.ver == IP_VERSION);
                else
                    do
                        h.ihl = 4'($urandom);
                    while (h.ihl == MIN_IHL);
            end
            else if (pick < 90)
                n = $urandom_range(1, 19);
            else
            begin
                n = $urandom_range(1, 40);
                noise = 1'b1;
            end
            send_packet(h, n, noise);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();
        run_random(0, 0);
        run_random(59, 0);
        run_random(0, 59);
        run_random(9, 9);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d packets (%0d bytes): header corner cases and short packets,",
                 packets_sent, bytes_sent);
        $display("random mixes under four handshake patterns; %0d payload results, %0d verdicts.",
                 payloads_seen, verdicts_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/iphp_pkg.sv
hw/rtl/iphp_front.sv
hw/rtl/iphp_queue.sv
hw/rtl/iphp_back.sv
hw/rtl/ipv4_header_parser.sv
verif/ipv4_header_parser_checker.sv
verif/ipv4_header_parser_tb.sv
